// File: hdl/md5_message_digest_top_defines.svh
// Assertion macros used by the MD5 digest checker.
`ifndef MD5_MESSAGE_DIGEST_TOP_DEFINES_SVH
`define MD5_MESSAGE_DIGEST_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define MD5_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("md5 checker: same-cycle implication violated");

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define MD5_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("md5 checker: next-cycle implication violated");

`endif

// File: hdl/md5_pkg.sv
// Shared constants, tables, types and helper functions of the MD5 digest block.
package md5_pkg;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam int         COUNT_W    = 61;

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Rotate amounts, indexed by {round group, round number mod 4}.
    localparam logic [4:0] ROT_AMT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

    // Kind of block a compression pass works on.
    typedef enum logic [1:0] {
        PASS_DATA,   // full block of message bytes
        PASS_LAST,   // tail bytes, pad byte, zeros and bit length
        PASS_PAD,    // tail bytes, pad byte and zeros; length follows in a second block
        PASS_LEN     // zeros and bit length only
    } pass_t;

    typedef struct packed {
        logic       init;   // load working words from the chaining words
        logic       step;   // run one round
        logic [5:0] rnd;    // round number
    } round_ctl_t;

    typedef struct packed {
        logic       wr_en;
        logic [5:0] wr_addr;
        logic [7:0] wr_data;
        logic [3:0] rd_addr;
    } buf_ctl_t;

    // Message word used by a given round.
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] lo;
        logic [3:0] idx;
        lo = rnd[3:0];
        case (rnd[5:4])
            2'd0:    idx = lo;
            2'd1:    idx = 4'(lo * 4'd5 + 4'd1);
            2'd2:    idx = 4'(lo * 4'd3 + 4'd5);
            default: idx = 4'(lo * 4'd7);
        endcase
        return idx;
    endfunction

endpackage

// File: hdl/md5_stream_if.sv
// Valid/ready channel interfaces for message bytes and digest words.
interface md5_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output has_byte,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input has_byte,
                    input end_of_message, output ready);
endinterface

interface md5_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

// File: hdl/md5_msg_buf.sv
// Block buffer memory with padding and length insertion on the read side.
module md5_msg_buf
    import md5_pkg::*;
(
    input  logic                 clk,
    input  buf_ctl_t             ctl,
    input  pass_t                pass,
    input  logic [COUNT_W-1:0]   count,
    output logic [31:0]          m_word
);

    logic [31:0] mem [16];
    logic [31:0] rdata_reg;
    logic [3:0]  widx_reg;
    logic [63:0] bit_len;
    logic [5:0]  fill;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr[5:2]][8*ctl.wr_addr[1:0] +: 8] <= ctl.wr_data;
        end
        rdata_reg <= mem[ctl.rd_addr];
        widx_reg  <= ctl.rd_addr;
    end

    assign bit_len = {count, 3'b000};
    assign fill    = count[5:0];

    // Bytes past the fill point are replaced by the pad byte, zeros or the length.
    always_comb
    begin
        logic [5:0] off;
        logic [2:0] lsel;
        logic [7:0] raw;
        logic [7:0] len_byte;
        logic       in_len;
        m_word = '0;
        for (int k = 0; k < 4; k++)
        begin
            off      = {widx_reg, 2'(k)};
            lsel     = {widx_reg[0], 2'(k)};
            raw      = rdata_reg[8*k +: 8];
            len_byte = bit_len[8*lsel +: 8];
            in_len   = (off >= LEN_OFFSET);
            case (pass)
                PASS_DATA:
                    m_word[8*k +: 8] = raw;
                PASS_LAST, PASS_PAD:
                begin
                    if (off < fill)
                        m_word[8*k +: 8] = raw;
                    else if (off == fill)
                        m_word[8*k +: 8] = PAD_BYTE;
                    else if (in_len && (pass == PASS_LAST))
                        m_word[8*k +: 8] = len_byte;
                    else
                        m_word[8*k +: 8] = 8'h00;
                end
                default:
                    m_word[8*k +: 8] = in_len ? len_byte : 8'h00;
            endcase
        end
    end

endmodule

// File: hdl/md5_round_unit.sv
// Shared MD5 round datapath: one round per cycle on the working words.
module md5_round_unit
    import md5_pkg::*;
(
    input  logic        clk,
    input  round_ctl_t  ctl,
    input  logic [31:0] m_word,
    input  logic [31:0] chain [4],
    output logic [31:0] work [4]
);

    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] pre_reg;   // a + K + M of the round that runs next
    logic [31:0] f_val;
    logic [31:0] sum_val;
    logic [63:0] rot_dbl;
    logic [31:0] b_next;
    logic [31:0] pre_base;
    logic [5:0]  k_idx;
    logic [31:0] pre_next;

    always_comb
    begin
        case (ctl.rnd[5:4])
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f_val = (d_reg & b_reg) | (~d_reg & c_reg);
            2'd2:    f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
    end

    assign sum_val = pre_reg + f_val;
    assign rot_dbl = {sum_val, sum_val} << ROT_AMT[{ctl.rnd[5:4], ctl.rnd[1:0]}];
    assign b_next  = b_reg + rot_dbl[63:32];

    // The next round's a is the current d, so its constant sum is formed in advance in pre_reg.
    assign pre_base = ctl.init ? chain[0] : d_reg;
    assign k_idx    = ctl.init ? 6'd0 : 6'(ctl.rnd + 6'd1);
    assign pre_next = pre_base + ROUND_K[k_idx] + m_word;

    always_ff @(posedge clk)
    begin
        if (ctl.init)
        begin
            a_reg   <= chain[0];
            b_reg   <= chain[1];
            c_reg   <= chain[2];
            d_reg   <= chain[3];
            pre_reg <= pre_next;
        end
        else if (ctl.step)
        begin
            a_reg   <= d_reg;
            d_reg   <= c_reg;
            c_reg   <= b_reg;
            b_reg   <= b_next;
            pre_reg <= pre_next;
        end
    end

    assign work[0] = a_reg;
    assign work[1] = b_reg;
    assign work[2] = c_reg;
    assign work[3] = d_reg;

endmodule

// File: hdl/md5_message_digest_top.sv
// MD5 digest top level: byte intake, block sequencer, chaining words and digest output.
//
//   channel | dir | fields                                   | transfer when
//   msg     | in  | data_byte[7:0], has_byte, end_of_message | msg.valid && msg.ready
//   digest  | out | digest_word[31:0], word_index[1:0], last | digest.valid && digest.ready
//
// A byte that does not complete a block leaves the block idle. A byte that completes a block
// runs a pass: S_LOAD0 and S_LOAD1 prime the buffer read and the round unit, the 64 rounds
// go through the single round unit, S_ADD folds into the chaining words. An end of message
// runs one or two such passes, then offers four digest words, one per cycle while
// digest.ready holds. msg.ready is high only while idle. Reset loads the initial chaining
// words and clears the byte count; the block buffer needs no clearing.
module md5_message_digest_top
    import md5_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    md5_in_if.sink          msg,
    md5_out_if.source       digest
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD0 = 3'd1;
    localparam logic [2:0] S_LOAD1 = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_ADD   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]         state_reg, state_next;
    pass_t              pass_reg, pass_next;
    logic               end_pend_reg, end_pend_next;
    logic [5:0]         rnd_reg, rnd_next;
    logic [1:0]         emit_idx_reg, emit_idx_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [31:0]        chain_reg [4];
    logic [31:0]        work [4];
    logic [31:0]        m_word;
    logic               msg_xfer;
    logic               dig_xfer;
    logic [5:0]         fill_after;
    pass_t              final_pass;
    buf_ctl_t           buf_ctl;
    round_ctl_t         round_ctl;

    assign msg_xfer = msg.valid && msg.ready;
    assign dig_xfer = digest.valid && digest.ready;

    assign msg.ready          = (state_reg == S_IDLE);
    assign digest.valid       = (state_reg == S_EMIT);
    assign digest.digest_word = chain_reg[emit_idx_reg];
    assign digest.word_index  = emit_idx_reg;
    assign digest.last_word   = (emit_idx_reg == 2'd3);

    // Tail length of the final block decides whether the length fits behind the pad byte.
    assign fill_after = msg.has_byte ? 6'(count_reg[5:0] + 6'd1) : count_reg[5:0];
    assign final_pass = (fill_after < LEN_OFFSET) ? PASS_LAST : PASS_PAD;

    always_comb
    begin
        buf_ctl.wr_en   = msg_xfer && msg.has_byte;
        buf_ctl.wr_addr = count_reg[5:0];
        buf_ctl.wr_data = msg.data_byte;
        unique case (state_reg)
            S_LOAD1: buf_ctl.rd_addr = msg_index(6'd1);
            S_ROUND: buf_ctl.rd_addr = msg_index(6'(rnd_reg + 6'd2));
            default: buf_ctl.rd_addr = msg_index(6'd0);
        endcase
        round_ctl.init = (state_reg == S_LOAD1);
        round_ctl.step = (state_reg == S_ROUND);
        round_ctl.rnd  = rnd_reg;
    end

    md5_msg_buf u_buf
    (
        .clk    (clk),
        .ctl    (buf_ctl),
        .pass   (pass_reg),
        .count  (count_reg),
        .m_word (m_word)
    );

    md5_round_unit u_round
    (
        .clk    (clk),
        .ctl    (round_ctl),
        .m_word (m_word),
        .chain  (chain_reg),
        .work   (work)
    );

    always_comb
    begin
        state_next    = state_reg;
        pass_next     = pass_reg;
        end_pend_next = end_pend_reg;
        rnd_next      = rnd_reg;
        emit_idx_next = emit_idx_reg;
        count_next    = count_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (msg_xfer)
                begin
                    if (msg.has_byte)
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                    if (msg.has_byte && (count_reg[5:0] == 6'd63))
                    begin
                        pass_next     = PASS_DATA;
                        end_pend_next = msg.end_of_message;
                        state_next    = S_LOAD0;
                    end
                    else if (msg.end_of_message)
                    begin
                        pass_next  = final_pass;
                        state_next = S_LOAD0;
                    end
                end
            end
            S_LOAD0:
                state_next = S_LOAD1;
            S_LOAD1:
            begin
                rnd_next   = 6'd0;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                rnd_next = 6'(rnd_reg + 6'd1);
                if (rnd_reg == 6'd63)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                case (pass_reg)
                    PASS_DATA:
                    begin
                        if (end_pend_reg)
                        begin
                            // The full block leaves an empty tail, so everything fits.
                            end_pend_next = 1'b0;
                            pass_next     = PASS_LAST;
                            state_next    = S_LOAD0;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    PASS_PAD:
                    begin
                        pass_next  = PASS_LEN;
                        state_next = S_LOAD0;
                    end
                    default:
                    begin
                        emit_idx_next = 2'd0;
                        state_next    = S_EMIT;
                    end
                endcase
            end
            S_EMIT:
            begin
                if (dig_xfer)
                begin
                    emit_idx_next = 2'(emit_idx_reg + 2'd1);
                    if (emit_idx_reg == 2'd3)
                    begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pass_reg     <= PASS_DATA;
            end_pend_reg <= 1'b0;
            rnd_reg      <= '0;
            emit_idx_reg <= '0;
            count_reg    <= '0;
            chain_reg[0] <= INIT_A;
            chain_reg[1] <= INIT_B;
            chain_reg[2] <= INIT_C;
            chain_reg[3] <= INIT_D;
        end
        else
        begin
            state_reg    <= state_next;
            pass_reg     <= pass_next;
            end_pend_reg <= end_pend_next;
            rnd_reg      <= rnd_next;
            emit_idx_reg <= emit_idx_next;
            count_reg    <= count_next;
            if (state_reg == S_ADD)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    chain_reg[k] <= chain_reg[k] + work[k];
                end
            end
            else if (dig_xfer && (emit_idx_reg == 2'd3))
            begin
                chain_reg[0] <= INIT_A;
                chain_reg[1] <= INIT_B;
                chain_reg[2] <= INIT_C;
                chain_reg[3] <= INIT_D;
            end
        end
    end

endmodule

// File: hdl/md5_chk.sv
// Port-level checker for the MD5 digest top level, attached by bind.
`include "md5_message_digest_top_defines.svh"

module md5_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_has_byte,
    input logic        in_end,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_word,
    input logic [1:0]  out_index,
    input logic        out_last
);

    // Intake and digest output never overlap.
    `MD5_ASSERT_IMP(a_no_overlap, out_valid, !in_ready)

    // A stalled digest word holds its value and position.
    `MD5_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_word) && $stable(out_index))

    // Digest words come in order without gaps.
    `MD5_ASSERT_NEXT(a_out_order, out_valid && out_ready && !out_last,
        out_valid && (out_index == 2'($past(out_index) + 2'd1)))

    // After the last word the block is idle again.
    `MD5_ASSERT_NEXT(a_back_idle, out_valid && out_ready && out_last, !out_valid && in_ready)

    // A transfer with neither flag leaves the block ready.
    `MD5_ASSERT_NEXT(a_empty_item, in_valid && in_ready && !in_has_byte && !in_end, in_ready)

endmodule

bind md5_message_digest_top md5_chk u_md5_chk
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (msg.valid),
    .in_ready    (msg.ready),
    .in_has_byte (msg.has_byte),
    .in_end      (msg.end_of_message),
    .out_valid   (digest.valid),
    .out_ready   (digest.ready),
    .out_word    (digest.digest_word),
    .out_index   (digest.word_index),
    .out_last    (digest.last_word)
);

// File: tb/tb_top.sv
// Self-checking testbench for the MD5 digest block: byte-stream stimulus and digest prediction.
package tb_digest_pkg;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  index;
        logic        last;
    } digest_word_t;

    // Keeps its own MD5 chaining state and queues the four digest words of each message.
    class digest_ledger;
        logic [7:0]   block_bytes [64];
        logic [60:0]  byte_count;
        logic [31:0]  chain [4];
        logic [31:0]  sine_k [64];
        int unsigned  shift_by [16];
        digest_word_t pending_words [$];
        int unsigned  mismatches;

        function new();
            real s;
            shift_by = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
            // The round constants are the integer part of |sin(i+1)| * 2^32.
            for (int i = 0; i < 64; i++)
            begin
                s = $sin(real'(i + 1));
                if (s < 0.0)
                    s = -s;
                sine_k[i] = 32'(longint'($floor(s * 4294967296.0)));
            end
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            chain = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
            byte_count = '0;
        endfunction

        function int pending();
            return pending_words.size();
        endfunction

        function void fold_block();
            logic [31:0] m [16];
            logic [31:0] a, b, c, d, f, t, sum;
            int          grp, w;
            int unsigned rot;
            for (int i = 0; i < 16; i++)
                m[i] = {block_bytes[4*i+3], block_bytes[4*i+2],
                        block_bytes[4*i+1], block_bytes[4*i]};
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            for (int i = 0; i < 64; i++)
            begin
                grp = i / 16;
                case (grp)
                    0:
                    begin
                        f = (b & c) | (~b & d);
                        w = i;
                    end
                    1:
                    begin
                        f = (d & b) | (~d & c);
                        w = (5 * i + 1) % 16;
                    end
                    2:
                    begin
                        f = b ^ c ^ d;
                        w = (3 * i + 5) % 16;
                    end
                    default:
                    begin
                        f = c ^ (b | ~d);
                        w = (7 * i) % 16;
                    end
                endcase
                rot = shift_by[grp * 4 + i % 4];
                sum = a + f + sine_k[i] + m[w];
                t = d;
                d = c;
                c = b;
                b = b + ((sum << rot) | (sum >> (32 - rot)));
                a = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
        endfunction

        function void note_input(logic [7:0] data, logic has_byte, logic eom);
            int           pos;
            logic [63:0]  bit_len;
            digest_word_t dw;
            if (has_byte)
            begin
                pos = int'(byte_count[5:0]);
                block_bytes[pos] = data;
                byte_count = byte_count + 61'd1;
                if (pos == 63)
                    fold_block();
            end
            if (!eom)
                return;
            pos = int'(byte_count[5:0]);
            block_bytes[pos] = 8'h80;
            pos++;
            // No room left for the length: finish this block and put it in one of its own.
            if (pos > 56)
            begin
                while (pos < 64)
                begin
                    block_bytes[pos] = 8'h00;
                    pos++;
                end
                fold_block();
                pos = 0;
            end
            while (pos < 56)
            begin
                block_bytes[pos] = 8'h00;
                pos++;
            end
            bit_len = {byte_count, 3'b000};
            for (int i = 0; i < 8; i++)
                block_bytes[56 + i] = bit_len[8*i +: 8];
            fold_block();
            for (int i = 0; i < 4; i++)
            begin
                dw.word  = chain[i];
                dw.index = 2'(i);
                dw.last  = (i == 3);
                pending_words.push_back(dw);
            end
            restart();
        endfunction

        function void note_error(string text);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", text);
        endfunction

        function void check_word(logic [31:0] word, logic [1:0] index, logic last);
            digest_word_t want;
            if (pending_words.size() == 0)
            begin
                note_error($sformatf("unexpected digest word %h index %0d last %0b",
                                     word, index, last));
                return;
            end
            want = pending_words.pop_front();
            if (want.word !== word || want.index !== index || want.last !== last)
                note_error($sformatf(
                    "digest word mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                    want.word, want.index, want.last, word, index, last));
        endfunction
    endclass

endpackage

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tb_digest_pkg::*;

    logic clk;
    logic rst_n;

    md5_in_if  msg_ch ();
    md5_out_if dig_ch ();

    md5_message_digest_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .digest (dig_ch)
    );

    digest_ledger book;
    bit           src_calm;
    int           boundary_lens [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Offers one item after a random gap and returns at the edge where it transfers.
    task automatic send_item(input logic [7:0] data, input logic has_byte, input logic eom);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 12);
        @(negedge clk);
        if (gap > 0)
        begin
            msg_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        msg_ch.valid          <= 1'b1;
        msg_ch.data_byte      <= data;
        msg_ch.has_byte       <= has_byte;
        msg_ch.end_of_message <= eom;
        do @(posedge clk); while (!msg_ch.ready);
        book.note_input(data, has_byte, eom);
    endtask

    // Withdraws the last offer so it cannot transfer twice, then waits for every digest word.
    task automatic drain();
        @(negedge clk);
        msg_ch.valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int         len;
        int         items;
        int         msgs;
        bit         end_with_byte;
        logic [7:0] b;
        book = new();
        src_calm = 1'b0;
        msg_ch.valid = 1'b0;
        msg_ch.data_byte = 8'h00;
        msg_ch.has_byte = 1'b0;
        msg_ch.end_of_message = 1'b0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty message, then hold off until its digest is out.
        send_item(8'h00, 1'b0, 1'b1);
        drain();
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h5A, 1'b0, 1'b1);
        drain();

        items = 0;
        msgs = 0;
        while (items < 250 || msgs < 12)
        begin
            case ($urandom_range(0, 4))
                0, 1:    len = $urandom_range(0, 8);
                2, 3:    len = boundary_lens[$urandom_range(0, 9)];
                default: len = $urandom_range(9, 70);
            endcase
            src_calm = ($urandom_range(0, 3) == 0);
            end_with_byte = (len > 0) && ($urandom_range(0, 1) == 1);
            for (int n = 0; n < len; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(8'($urandom), 1'b0, 1'b0);
                if ($urandom_range(0, 7) == 0)
                    b = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
                else
                    b = 8'($urandom);
                send_item(b, 1'b1, end_with_byte && (n == len - 1));
                items++;
            end
            if (!end_with_byte)
            begin
                send_item(8'($urandom), 1'b0, 1'b1);
                items++;
            end
            msgs++;
            if (msgs == 6)
                drain();
        end
        @(negedge clk);
        msg_ch.valid <= 1'b0;

        drain();
        repeat (100) @(posedge clk);
        if (book.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin : digest_sink
        int stall;
        int seen;
        bit calm;
        seen = 0;
        calm = 1'b0;
        dig_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (seen % 16 == 0)
                calm = ($urandom_range(0, 2) == 0);
            stall = calm ? 0 : $urandom_range(0, 12);
            // A long hold-off in the middle of a digest, so the byte input backs up behind it.
            if (seen == 21)
                stall = 400;
            @(negedge clk);
            if (stall > 0)
            begin
                dig_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            dig_ch.ready <= 1'b1;
            do @(posedge clk); while (!dig_ch.valid);
            book.check_word(dig_ch.digest_word, dig_ch.word_index, dig_ch.last_word);
            seen++;
        end
    end

    initial
    begin : watchdog
        #(5_000_000);
        $display("Mismatches found");
        $finish;
    end

endmodule
